// ===== rtl/ipsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipsa_pkg
// Shared types, codes and sizes of the security association table.
// ----------------------------------------------------------------------------
package ipsa_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ADDR_WIDTH  = 32;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned STAT_W      = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSTALL = 3'd0,
    REQ_ERASE   = 3'd1,
    REQ_INBOUND = 3'd2,
    REQ_OUT_ID  = 3'd3,
    REQ_OUT_POL = 3'd4,
    REQ_BY_ID   = 3'd5
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSTALLED = 4'd0,
    ST_REPLACED  = 4'd1,
    ST_INVALID   = 4'd2,
    ST_CONFLICT  = 4'd3,
    ST_FULL      = 4'd4,
    ST_ERASED    = 4'd5,
    ST_MISSING   = 4'd6,
    ST_FOUND     = 4'd7,
    ST_NOT_FOUND = 4'd8
  } status_e;

  // Match ranks of an inbound lookup.
  localparam logic [1:0] SPEC_NONE     = 2'd0;
  localparam logic [1:0] SPEC_SPI      = 2'd1;
  localparam logic [1:0] SPEC_DEST     = 2'd2;
  localparam logic [1:0] SPEC_SRC_DEST = 2'd3;

  typedef struct packed {
    logic [63:0]           id;
    logic [31:0]           policy;
    logic [31:0]           spi;
    logic                  proto;
    logic                  outbound;
    logic                  dest_present;
    logic [ADDR_WIDTH-1:0] dest;
    logic                  src_present;
    logic [ADDR_WIDTH-1:0] src;
    logic [63:0]           created;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;
    logic scan_step;
    logic commit;
    logic shift_step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic erase_hit;
    logic shift_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/ipsa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipsa_dp
// Table storage, request registers, slot scan trackers and result register.
// ----------------------------------------------------------------------------
module ipsa_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ipsa_pkg::cmd_t                 cmd_i,
  output ipsa_pkg::sts_t                      sts_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [ipsa_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic [ipsa_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [63:0]                    sa_id_i,
  input  wire logic [31:0]                    policy_key_i,
  input  wire logic [31:0]                    spi_value_i,
  input  wire logic                           proto_sel_i,
  input  wire logic                           is_outbound_i,
  input  wire logic                           dest_present_i,
  input  wire logic [ipsa_pkg::ADDR_WIDTH-1:0] dest_addr_i,
  input  wire logic                           src_present_i,
  input  wire logic [ipsa_pkg::ADDR_WIDTH-1:0] src_addr_i,
  input  wire logic [63:0]                    created_time_i,
  output logic [ipsa_pkg::STAT_W-1:0]         status_o,
  output logic                                hit_o,
  output logic [63:0]                         match_id_o,
  output logic [31:0]                         match_policy_o,
  output logic [ipsa_pkg::IDX_W-1:0]          match_slot_o
);
  import ipsa_pkg::*;

  entry_t               tbl_q [TABLE_DEPTH];
  logic [REQ_W-1:0]     req_q;
  entry_t               new_q;
  logic [CFG_W-1:0]     cap_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     sh_q, sh_d;
  logic                 sel_hit_q, sel_hit_d;
  logic                 conf_q, conf_d;
  logic [1:0]           best_q, best_d;
  logic [IDX_W-1:0]     sel_idx_q, sel_idx_d;
  logic [63:0]          sel_id_q, sel_id_d;
  logic [31:0]          sel_pol_q, sel_pol_d;
  logic [63:0]          sel_created_q, sel_created_d;

  entry_t               cur;
  logic                 in_range, id_eq, take, conflict, same_key;
  logic [1:0]           spec;
  logic [CNT_W-1:0]     sh_next;
  logic                 sh_more;
  logic                 invalid, full;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [STAT_W-1:0]    res_status;

  assign cur      = tbl_q[idx_q[IDX_W-1:0]];
  assign in_range = idx_q < count_q;
  assign id_eq    = cur.id == new_q.id;

  // Inbound rank of the slot under the scan pointer.
  always_comb begin
    spec = SPEC_NONE;
    if (!cur.outbound && cur.spi == new_q.spi && cur.proto == new_q.proto &&
        !(cur.dest_present && cur.dest != new_q.dest) &&
        !(cur.src_present && cur.src != new_q.src)) begin
      spec = cur.src_present ? SPEC_SRC_DEST : (cur.dest_present ? SPEC_DEST : SPEC_SPI);
    end
  end

  // new_q holds the unmasked request key, so mask it to the stored form to compare.
  assign same_key = cur.spi == new_q.spi && cur.proto == new_q.proto &&
                    cur.dest_present == new_q.dest_present &&
                    cur.dest == (new_q.dest_present ? new_q.dest : '0) &&
                    cur.src_present == new_q.src_present &&
                    cur.src == (new_q.src_present ? new_q.src : '0);
  assign conflict = (req_q == REQ_INSTALL) && !id_eq &&
                    cur.outbound == new_q.outbound && same_key;

  always_comb begin
    case (req_q) inside
      REQ_INSTALL, REQ_ERASE, REQ_BY_ID: take = id_eq && !sel_hit_q;
      REQ_OUT_ID:  take = id_eq && cur.outbound && !sel_hit_q;
      REQ_INBOUND: take = (new_q.spi != '0) && (spec > best_q);
      REQ_OUT_POL: take = cur.outbound && cur.policy == new_q.policy &&
                          cur.proto == new_q.proto &&
                          (!sel_hit_q || cur.created > sel_created_q ||
                           (cur.created == sel_created_q && cur.id > sel_id_q));
      default:     take = 1'b0;
    endcase
  end

  assign sh_next = sh_q + CNT_W'(1);
  assign sh_more = sh_next < count_q;

  assign invalid = new_q.id == '0 || new_q.policy == '0 || new_q.spi == '0 ||
                   (new_q.src_present && !new_q.dest_present);
  assign full    = ((CNT_W + CFG_W)'(count_q) >= (CNT_W + CFG_W)'(cap_q)) ||
                   (count_q == CNT_W'(TABLE_DEPTH));

  always_comb begin
    res_status = ST_INVALID;
    wr_en      = 1'b0;
    wr_idx     = count_q[IDX_W-1:0];
    case (req_q) inside
      REQ_INSTALL: begin
        if (invalid) begin
          res_status = ST_INVALID;
        end else if (conf_q) begin
          res_status = ST_CONFLICT;
        end else if (sel_hit_q) begin
          res_status = ST_REPLACED;
          wr_en      = 1'b1;
          wr_idx     = sel_idx_q;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_INSTALLED;
          wr_en      = 1'b1;
        end
      end
      REQ_ERASE: res_status = sel_hit_q ? ST_ERASED : ST_MISSING;
      REQ_INBOUND, REQ_OUT_ID, REQ_OUT_POL, REQ_BY_ID: begin
        res_status = sel_hit_q ? ST_FOUND : ST_NOT_FOUND;
      end
      default: res_status = ST_INVALID;
    endcase
  end

  // Scan trackers, counters.
  always_comb begin
    idx_d         = idx_q;
    sel_hit_d     = sel_hit_q;
    conf_d        = conf_q;
    best_d        = best_q;
    sel_idx_d     = sel_idx_q;
    sel_id_d      = sel_id_q;
    sel_pol_d     = sel_pol_q;
    sel_created_d = sel_created_q;
    count_d       = count_q;
    sh_d          = sh_q;
    if (cmd_i.load_req) begin
      idx_d     = '0;
      sel_hit_d = 1'b0;
      conf_d    = 1'b0;
      best_d    = SPEC_NONE;
    end else if (cmd_i.scan_step && in_range) begin
      idx_d = idx_q + CNT_W'(1);
      if (take) begin
        sel_hit_d     = 1'b1;
        sel_idx_d     = idx_q[IDX_W-1:0];
        sel_id_d      = cur.id;
        sel_pol_d     = cur.policy;
        sel_created_d = cur.created;
        best_d        = spec;
      end
      if (conflict) begin
        conf_d = 1'b1;
      end
    end
    if (cmd_i.commit) begin
      sh_d = CNT_W'(sel_idx_q);
      if (req_q == REQ_INSTALL && wr_en && !sel_hit_q) begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.shift_step) begin
      if (sh_more) begin
        sh_d = sh_next;
      end else begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CFG_W'(16);
      count_q   <= '0;
      idx_q     <= '0;
      sh_q      <= '0;
      sel_hit_q <= 1'b0;
      conf_q    <= 1'b0;
      best_q    <= SPEC_NONE;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      count_q   <= count_d;
      idx_q     <= idx_d;
      sh_q      <= sh_d;
      sel_hit_q <= sel_hit_d;
      conf_q    <= conf_d;
      best_q    <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_idx_q     <= sel_idx_d;
    sel_id_q      <= sel_id_d;
    sel_pol_q     <= sel_pol_d;
    sel_created_q <= sel_created_d;
    if (cmd_i.load_req) begin
      req_q              <= req_type_i;
      new_q.id           <= sa_id_i;
      new_q.policy       <= policy_key_i;
      new_q.spi          <= spi_value_i;
      new_q.proto        <= proto_sel_i;
      new_q.outbound     <= is_outbound_i;
      new_q.dest_present <= dest_present_i;
      new_q.dest         <= dest_addr_i;
      new_q.src_present  <= src_present_i;
      new_q.src          <= src_addr_i;
      new_q.created      <= created_time_i;
    end
    if (cmd_i.commit) begin
      status_o <= res_status;
      if (req_q != REQ_INSTALL && req_q != REQ_ERASE && sel_hit_q) begin
        hit_o          <= 1'b1;
        match_id_o     <= sel_id_q;
        match_policy_o <= sel_pol_q;
        match_slot_o   <= sel_idx_q;
      end else begin
        hit_o          <= 1'b0;
        match_id_o     <= '0;
        match_policy_o <= '0;
        match_slot_o   <= '0;
      end
    end
  end

  // Table writes: install or replace at commit, one-slot move down per shift step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      tbl_q[wr_idx] <= '{id:           new_q.id,
                         policy:       new_q.policy,
                         spi:          new_q.spi,
                         proto:        new_q.proto,
                         outbound:     new_q.outbound,
                         dest_present: new_q.dest_present,
                         dest:         new_q.dest_present ? new_q.dest : '0,
                         src_present:  new_q.src_present,
                         src:          new_q.src_present ? new_q.src : '0,
                         created:      new_q.created};
    end else if (cmd_i.shift_step && sh_more) begin
      tbl_q[sh_q[IDX_W-1:0]] <= tbl_q[sh_next[IDX_W-1:0]];
    end
  end

  assign sts_o.scan_done  = !in_range;
  assign sts_o.erase_hit  = (req_q == REQ_ERASE) && sel_hit_q;
  assign sts_o.shift_done = !sh_more;

endmodule
`default_nettype wire

// ===== rtl/ipsa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipsa_ctrl
// Request sequencer: accept, scan, decide and answer, close erase gaps.
// ----------------------------------------------------------------------------
module ipsa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ipsa_pkg::cmd_t      cmd_o,
  input  wire ipsa_pkg::sts_t sts_i
);
  import ipsa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_ANY    = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  assign cmd_o.load_req   = in_valid_i && in_ready_o;
  assign cmd_o.scan_step  = state_q == S_SCAN;
  assign cmd_o.commit     = (state_q == S_DECIDE) && out_free;
  assign cmd_o.shift_step = state_q == S_SHIFT;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (cmd_o.load_req) state_d = S_SCAN;
      S_SCAN:   if (sts_i.scan_done) state_d = S_DECIDE;
      S_DECIDE: if (out_free) state_d = sts_i.erase_hit ? S_SHIFT : S_IDLE;
      S_SHIFT:  if (sts_i.shift_done) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/ipsec_sa_table_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipsec_sa_table_match
// Security association table with install, erase and keyed lookups.
// ----------------------------------------------------------------------------
// One request at a time. A request is accepted, scanned over every live
// entry, and decided; the decision loads the result register once the
// previous answer is taken. An erase that hits then moves each later entry
// down one slot, one per cycle, and then drops the count. The single scan
// pointer over the slot registers visits the entries in turn. The result
// register holds an answer until taken while the next request is already
// accepted and scanned. Write the capacity register only while no request
// is in flight; an install reads it when it decides.
module ipsec_sa_table_match (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [ipsa_pkg::REQ_W-1:0]      req_type_i,
  input  wire logic [63:0]                     sa_id_i,
  input  wire logic [31:0]                     policy_key_i,
  input  wire logic [31:0]                     spi_value_i,
  input  wire logic                            proto_sel_i,
  input  wire logic                            is_outbound_i,
  input  wire logic                            dest_present_i,
  input  wire logic [ipsa_pkg::ADDR_WIDTH-1:0] dest_addr_i,
  input  wire logic                            src_present_i,
  input  wire logic [ipsa_pkg::ADDR_WIDTH-1:0] src_addr_i,
  input  wire logic [63:0]                     created_time_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [ipsa_pkg::STAT_W-1:0]          status_o,
  output logic                                 hit_o,
  output logic [63:0]                          match_id_o,
  output logic [31:0]                          match_policy_o,
  output logic [ipsa_pkg::IDX_W-1:0]           match_slot_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ipsa_pkg::CFG_W-1:0]      cfg_data_i
);
  import ipsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Always take capacity writes.
  assign cfg_ready_o = 1'b1;

  ipsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ipsa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .sa_id_i        (sa_id_i),
    .policy_key_i   (policy_key_i),
    .spi_value_i    (spi_value_i),
    .proto_sel_i    (proto_sel_i),
    .is_outbound_i  (is_outbound_i),
    .dest_present_i (dest_present_i),
    .dest_addr_i    (dest_addr_i),
    .src_present_i  (src_present_i),
    .src_addr_i     (src_addr_i),
    .created_time_i (created_time_i),
    .status_o       (status_o),
    .hit_o          (hit_o),
    .match_id_o     (match_id_o),
    .match_policy_o (match_policy_o),
    .match_slot_o   (match_slot_o)
  );

  // A hit always reports found.
  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> status_o == ST_FOUND)
    else $error("hit without found status");

  // A miss carries zero match fields.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> match_id_o == '0 && match_policy_o == '0 &&
                              match_slot_o == '0)
    else $error("miss with nonzero match fields");

  // An accepted request blocks the next one while it scans.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted during scan");

endmodule
`default_nettype wire
